@@ rtl/ppp_pkg.sv @@
`timescale 1ns / 1ps
// Package for the pinhole point projector: request codes, store layout and
// the fixed widths of the internal datapath. No dependencies.
package ppp_pkg;

  // Request codes carried in the op field.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  // Coefficient store layout.
  localparam int STORE_DEPTH = 21;
  localparam int POS_BASE    = 9;
  localparam int K_BASE      = 12;
  localparam int IDX_W       = 5;

  // Fixed-point datapath widths.
  localparam int FRAC_BITS    = 16;
  localparam int PROD_LIM_EXP = 60;
  localparam int PROD_W       = 62;
  localparam int SUM_W        = 64;
  localparam int F_BITS       = 58;
  localparam int NUM_W        = 66;
  localparam int DEN_W        = 60;
  localparam int NOISE_W      = 4;

endpackage

@@ rtl/ppp_item_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces for the projector: input requests and pixel results.
// Depends on ppp_pkg for the index width.
interface ppp_item_if #(parameter int COEF_WIDTH = 32);
  logic                                 valid;
  logic                                 ready;
  logic                                 op;
  logic [ppp_pkg::IDX_W-1:0]            coef_index;
  logic signed [COEF_WIDTH-1:0]         coef_value;
  logic signed [COEF_WIDTH-1:0]         point_x;
  logic signed [COEF_WIDTH-1:0]         point_y;
  logic signed [COEF_WIDTH-1:0]         point_z;
  logic                                 noise_en;
  logic signed [ppp_pkg::NOISE_W-1:0]   noise_u;
  logic signed [ppp_pkg::NOISE_W-1:0]   noise_v;

  modport source (output valid, op, coef_index, coef_value, point_x, point_y, point_z,
                  noise_en, noise_u, noise_v, input ready);
  modport sink (input valid, op, coef_index, coef_value, point_x, point_y, point_z,
                noise_en, noise_u, noise_v, output ready);
endinterface

interface ppp_result_if #(parameter int PIXEL_WIDTH = 16);
  logic                          valid;
  logic                          ready;
  logic                          visible;
  logic                          clipped;
  logic signed [PIXEL_WIDTH-1:0] pixel_u;
  logic signed [PIXEL_WIDTH-1:0] pixel_v;

  modport source (output valid, visible, clipped, pixel_u, pixel_v, input ready);
  modport sink (input valid, visible, clipped, pixel_u, pixel_v, output ready);
endinterface

@@ rtl/ppp_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts requests, applies coefficient writes to the store and
// forwards projection requests to the queue. Depends on ppp_pkg, ppp_item_if.
module ppp_front #(
  parameter int COEF_WIDTH = 32,
  parameter int QW         = 3 * 32 + 9
) (
  input  logic                         clk,
  ppp_item_if.sink                     item,
  output logic signed [COEF_WIDTH-1:0] coef [ppp_pkg::STORE_DEPTH],
  output logic                         q_push,
  output logic [QW-1:0]                q_data,
  input  logic                         q_full,
  input  logic                         q_empty,
  input  logic                         back_busy
);
  import ppp_pkg::*;

  logic is_write;
  logic take;

  // A write waits until every projection ahead of it has read the store.
  assign is_write   = (item.op == OP_WRITE);
  assign item.ready = is_write ? (q_empty && !back_busy) : !q_full;
  assign take       = item.valid && item.ready;
  assign q_push     = take && !is_write;
  assign q_data     = {item.noise_en, item.noise_u, item.noise_v,
                       item.point_x, item.point_y, item.point_z};

  // Coefficient store; writes beyond the last entry are dropped.
  always_ff @(posedge clk) begin
    if (take && is_write) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        if (item.coef_index == IDX_W'(i)) begin
          coef[i] <= item.coef_value;
        end
      end
    end
  end
endmodule

@@ rtl/ppp_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue between the front end and the datapath.
// Depends on nothing but its width parameter.
module ppp_queue #(
  parameter int QW = 105
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [QW-1:0] wdata,
  input  logic          pop,
  output logic [QW-1:0] rdata,
  output logic          full,
  output logic          empty
);
  logic [QW-1:0] mem [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  // Pointer and fill-level bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end
endmodule

@@ rtl/ppp_div.sv @@
`timescale 1ns / 1ps
// Pipelined signed divider, one quotient bit per stage, truncating toward
// zero and saturating to QW bits. Depends on ppp_pkg.
module ppp_div #(
  parameter int QW = 16
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [ppp_pkg::NUM_W-1:0] num,
  input  logic signed [ppp_pkg::DEN_W-1:0] den,
  output logic signed [QW-1:0]             quot,
  output logic                             clip
);
  import ppp_pkg::*;

  localparam int CW = NUM_W + QW;

  logic [NUM_W-1:0] na;
  logic [DEN_W-1:0] da;
  logic             neg_a;
  logic [CW-1:0]    rem [QW+1];
  logic [QW-1:0]    quo [QW+1];
  logic [DEN_W-1:0] dsh [QW+1];
  logic             neg [QW+1];
  logic             ovf [QW+1];

  // Magnitudes and result sign.
  always_ff @(posedge clk) begin
    if (en) begin
      na    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      da    <= den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
      neg_a <= num[NUM_W-1] ^ den[DEN_W-1];
    end
  end

  // Quotient magnitudes of more than QW bits are flagged to saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= CW'(na);
      quo[0] <= '0;
      dsh[0] <= da;
      neg[0] <= neg_a;
      ovf[0] <= CW'(na) >= (CW'(da) << QW);
    end
  end

  // One restoring step per stage, most significant bit first.
  for (genvar g = 0; g < QW; g++) begin : g_step
    localparam int K = QW - 1 - g;
    logic [CW-1:0] sub;
    logic          ge;
    assign sub = CW'(dsh[g]) << K;
    assign ge  = rem[g] >= sub;
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= ge ? rem[g] - sub : rem[g];
        quo[g+1] <= quo[g] | (QW'(ge) << K);
        dsh[g+1] <= dsh[g];
        neg[g+1] <= neg[g];
        ovf[g+1] <= ovf[g];
      end
    end
  end

  logic [QW-1:0] qa;
  logic          over;
  assign qa   = quo[QW];
  assign over = ovf[QW] ||
                (neg[QW] ? (qa > (QW'(1) << (QW - 1)))
                         : (qa > ((QW'(1) << (QW - 1)) - QW'(1))));

  // Apply sign and saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      clip <= over;
      if (over) begin
        quot <= neg[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else begin
        quot <= neg[QW] ? -qa : qa;
      end
    end
  end
endmodule

@@ rtl/ppp_back.sv @@
`timescale 1ns / 1ps
// Datapath: camera transform, intrinsic matrix, pixel division and the
// output register. Depends on ppp_pkg, ppp_result_if and ppp_div.
module ppp_back #(
  parameter int COEF_WIDTH  = 32,
  parameter int PIXEL_WIDTH = 16,
  parameter int QW          = 3 * 32 + 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic signed [COEF_WIDTH-1:0] coef [ppp_pkg::STORE_DEPTH],
  input  logic                        q_valid,
  input  logic [QW-1:0]               q_data,
  output logic                        q_pop,
  output logic                        busy,
  ppp_result_if.source                result
);
  import ppp_pkg::*;

  localparam int W    = COEF_WIDTH;
  localparam int XW   = (2 * W > SUM_W) ? 2 * W : SUM_W;
  localparam int DLAT = PIXEL_WIDTH + 3;
  localparam int NST  = 6;

  // Signed saturation bounds of the intermediate results.
  localparam logic signed [W:0]       D_MAX = {2'b00, {(W-1){1'b1}}};
  localparam logic signed [W:0]       D_MIN = ~D_MAX;
  localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'({1'b0, {(W-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] C_MIN = ~C_MAX;
  localparam logic signed [SUM_W-1:0] F_MAX = SUM_W'({1'b0, {(F_BITS-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] F_MIN = ~F_MAX;

  logic en;
  logic v [NST];
  logic vd [DLAT];
  logic visd [DLAT];

  assign en    = !result.valid || result.ready;
  assign q_pop = en && q_valid;

  // Product of two Q16 values: floor, then clamp to plus or minus 2^60.
  function automatic logic signed [PROD_W-1:0] q16(input logic signed [2*W-1:0] p);
    logic signed [XW-1:0] s;
    logic signed [XW-1:0] lim;
    s   = XW'(p) >>> FRAC_BITS;
    lim = XW'(1) <<< PROD_LIM_EXP;
    if (s > lim) return PROD_W'(lim);
    if (s < -lim) return PROD_W'(-lim);
    return PROD_W'(s);
  endfunction

  // Stage 1: unpack and subtract the camera position.
  logic signed [W-1:0]       pin [3];
  logic signed [W-1:0]       d [3];
  logic                      an1;
  logic signed [NOISE_W-1:0] nu1, nv1;
  assign pin[0] = q_data[3*W-1 -: W];
  assign pin[1] = q_data[2*W-1 -: W];
  assign pin[2] = q_data[W-1 -: W];

  always_ff @(posedge clk) begin
    logic signed [W:0] df;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        df = (W+1)'(pin[i]) - (W+1)'(coef[POS_BASE+i]);
        if (df > D_MAX) d[i] <= {1'b0, {(W-1){1'b1}}};
        else if (df < D_MIN) d[i] <= {1'b1, {(W-1){1'b0}}};
        else d[i] <= W'(df);
      end
      an1 <= q_data[QW-1];
      nu1 <= q_data[QW-2 -: NOISE_W];
      nv1 <= q_data[QW-2-NOISE_W -: NOISE_W];
    end
  end

  // Stage 2: transposed rotation products.
  logic signed [2*W-1:0]     p1 [3][3];
  logic                      an2;
  logic signed [NOISE_W-1:0] nu2, nv2;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p1[i][j] <= coef[j*3+i] * d[j];
      an2 <= an1; nu2 <= nu1; nv2 <= nv1;
    end
  end

  // Stage 3: camera point, saturated to the coefficient width.
  logic signed [W-1:0]       c [3];
  logic                      an3;
  logic signed [NOISE_W-1:0] nu3, nv3;
  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] s;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s = SUM_W'(q16(p1[i][0])) + SUM_W'(q16(p1[i][1])) + SUM_W'(q16(p1[i][2]));
        if (s > C_MAX) c[i] <= {1'b0, {(W-1){1'b1}}};
        else if (s < C_MIN) c[i] <= {1'b1, {(W-1){1'b0}}};
        else c[i] <= W'(s);
      end
      an3 <= an2; nu3 <= nu2; nv3 <= nv2;
    end
  end

  // Stage 4: intrinsic matrix products.
  logic signed [2*W-1:0]     p2 [3][3];
  logic                      front4;
  logic                      an4;
  logic signed [NOISE_W-1:0] nu4, nv4;
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          p2[i][j] <= coef[K_BASE+i*3+j] * c[j];
      front4 <= !c[2][W-1];
      an4 <= an3; nu4 <= nu3; nv4 <= nv3;
    end
  end

  // Stage 5: image-plane vector, saturated to the fixed intermediate width.
  logic signed [F_BITS-1:0]  f [3];
  logic                      front5;
  logic                      an5;
  logic signed [NOISE_W-1:0] nu5, nv5;
  always_ff @(posedge clk) begin
    logic signed [SUM_W-1:0] s;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s = SUM_W'(q16(p2[i][0])) + SUM_W'(q16(p2[i][1])) + SUM_W'(q16(p2[i][2]));
        if (s > F_MAX) f[i] <= {1'b0, {(F_BITS-1){1'b1}}};
        else if (s < F_MIN) f[i] <= {1'b1, {(F_BITS-1){1'b0}}};
        else f[i] <= F_BITS'(s);
      end
      front5 <= front4;
      an5 <= an4; nu5 <= nu4; nv5 <= nv4;
    end
  end

  // Stage 6: rounding numerators with noise, and the common divisor.
  logic signed [NUM_W-1:0] num_u, num_v;
  logic signed [DEN_W-1:0] den;
  logic                    vis6;
  always_ff @(posedge clk) begin
    logic signed [NOISE_W+1:0] mu, mv;
    if (en) begin
      mu = an5 ? ((NOISE_W+2)'(nu5) <<< 1) + (NOISE_W+2)'(1) : (NOISE_W+2)'(1);
      mv = an5 ? ((NOISE_W+2)'(nv5) <<< 1) + (NOISE_W+2)'(1) : (NOISE_W+2)'(1);
      num_u <= (NUM_W'(f[0]) <<< 1) + NUM_W'(mu) * NUM_W'(f[2]);
      num_v <= (NUM_W'(f[1]) <<< 1) + NUM_W'(mv) * NUM_W'(f[2]);
      den   <= DEN_W'(f[2]) <<< 1;
      vis6  <= front5 && (f[2] != '0);
    end
  end

  // Pixel dividers.
  logic signed [PIXEL_WIDTH-1:0] qu, qv;
  logic                          cu, cv;
  ppp_div #(.QW(PIXEL_WIDTH)) u_div_u (
    .clk(clk), .en(en), .num(num_u), .den(den), .quot(qu), .clip(cu));
  ppp_div #(.QW(PIXEL_WIDTH)) u_div_v (
    .clk(clk), .en(en), .num(num_v), .den(den), .quot(qv), .clip(cv));

  // Valid bits through the whole pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NST; i++) v[i] <= 1'b0;
      for (int i = 0; i < DLAT; i++) vd[i] <= 1'b0;
    end else if (en) begin
      v[0] <= q_valid;
      for (int i = 1; i < NST; i++) v[i] <= v[i-1];
      vd[0] <= v[NST-1];
      for (int i = 1; i < DLAT; i++) vd[i] <= vd[i-1];
    end
  end

  // Visibility travels alongside the dividers.
  always_ff @(posedge clk) begin
    if (en) begin
      visd[0] <= vis6;
      for (int i = 1; i < DLAT; i++) visd[i] <= visd[i-1];
    end
  end

  always_comb begin
    busy = 1'b0;
    for (int i = 0; i < NST; i++) busy = busy | v[i];
    for (int i = 0; i < DLAT; i++) busy = busy | vd[i];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= vd[DLAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.visible <= visd[DLAT-1];
      result.clipped <= visd[DLAT-1] && (cu || cv);
      result.pixel_u <= visd[DLAT-1] ? qu : '0;
      result.pixel_v <= visd[DLAT-1] ? qv : '0;
    end
  end
endmodule

@@ rtl/pinhole_point_projector.sv @@
`timescale 1ns / 1ps
// Top level of the pinhole point projector: front end, queue and datapath.
// Depends on ppp_pkg, the channel interfaces and the ppp_* modules.
//
// Projection requests are taken at one per clock cycle while the result
// channel is not stalled, and each gives one result after it passes the
// queue, six arithmetic stages, the first of which reads the queue directly,
// a divider with one quotient bit per stage plus three, and the output
// register. A coefficient write gives no result; it is held at the input
// until every projection already accepted has reached the output register,
// since those projections read the coefficient store stage by stage.
// Coefficients read before they are written give undefined pixels.
module pinhole_point_projector #(
  parameter int COEF_WIDTH  = 32,
  parameter int PIXEL_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  ppp_item_if.sink     item,
  ppp_result_if.source result
);
  import ppp_pkg::*;

  localparam int QW = 3 * COEF_WIDTH + 2 * NOISE_W + 1;

  logic signed [COEF_WIDTH-1:0] coef [STORE_DEPTH];
  logic                         q_push, q_pop, q_full, q_empty, back_busy;
  logic [QW-1:0]                q_wdata, q_rdata;

  ppp_front #(.COEF_WIDTH(COEF_WIDTH), .QW(QW)) u_front (
    .clk(clk), .item(item), .coef(coef), .q_push(q_push),
    .q_data(q_wdata), .q_full(q_full), .q_empty(q_empty), .back_busy(back_busy));

  ppp_queue #(.QW(QW)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata), .pop(q_pop),
    .rdata(q_rdata), .full(q_full), .empty(q_empty));

  ppp_back #(.COEF_WIDTH(COEF_WIDTH), .PIXEL_WIDTH(PIXEL_WIDTH), .QW(QW)) u_back (
    .clk(clk), .rst(rst), .coef(coef), .q_valid(!q_empty), .q_data(q_rdata),
    .q_pop(q_pop), .busy(back_busy), .result(result));
endmodule
